// File: rtl/r4cp_pkg.sv
// Shared types and constants for the RGB565 four-color packer.
package r4cp_pkg;

   // Channel and arithmetic widths
   localparam int PIXEL_W = 16;
   localparam int CHAN_W  = 8;
   localparam int SUM_W   = 18;   // 299*255 + 587*255 + 114*255 = 255000
   localparam int CODE_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int CSR_INDEX_W = 4;

   // Luminance weights and threshold scale
   localparam logic [SUM_W-1:0] WEIGHT_R  = 18'd299;
   localparam logic [SUM_W-1:0] WEIGHT_G  = 18'd587;
   localparam logic [SUM_W-1:0] WEIGHT_B  = 18'd114;
   localparam logic [SUM_W-1:0] LUM_SCALE = 18'd1000;

   // Color codes
   localparam logic [CODE_W-1:0] COLOR_BLACK  = 2'd0;
   localparam logic [CODE_W-1:0] COLOR_WHITE  = 2'd1;
   localparam logic [CODE_W-1:0] COLOR_YELLOW = 2'd2;
   localparam logic [CODE_W-1:0] COLOR_RED    = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SAT_LIMIT        = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LUM_LIMIT        = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_YELLOW_RED_MIN   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_YELLOW_GREEN_MIN = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_YELLOW_BLUE_MAX  = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RED_RED_MIN      = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RED_GREEN_MAX    = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_RED_BLUE_MAX     = 4'd7;

   // Register reset values
   localparam logic [CHAN_W-1:0] RST_SAT_LIMIT        = 8'd45;
   localparam logic [CHAN_W-1:0] RST_LUM_LIMIT        = 8'd160;
   localparam logic [CHAN_W-1:0] RST_YELLOW_RED_MIN   = 8'd150;
   localparam logic [CHAN_W-1:0] RST_YELLOW_GREEN_MIN = 8'd130;
   localparam logic [CHAN_W-1:0] RST_YELLOW_BLUE_MAX  = 8'd100;
   localparam logic [CHAN_W-1:0] RST_RED_RED_MIN      = 8'd140;
   localparam logic [CHAN_W-1:0] RST_RED_GREEN_MAX    = 8'd110;
   localparam logic [CHAN_W-1:0] RST_RED_BLUE_MAX     = 8'd110;

   // Configuration register set
   typedef struct packed {
      logic [CHAN_W-1:0] sat_limit;
      logic [CHAN_W-1:0] lum_limit;
      logic [CHAN_W-1:0] yellow_red_min;
      logic [CHAN_W-1:0] yellow_green_min;
      logic [CHAN_W-1:0] yellow_blue_max;
      logic [CHAN_W-1:0] red_red_min;
      logic [CHAN_W-1:0] red_green_max;
      logic [CHAN_W-1:0] red_blue_max;
   } cfg_type;

   // One classified pixel on its way to the packer
   typedef struct packed {
      logic              frame_start;
      logic [CODE_W-1:0] code;
   } entry_type;

endpackage

// File: rtl/r4cp_classify.sv
// Front end: accepts pixels, expands channels and classifies each into a color code.
module r4cp_classify #(
   parameter int DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [r4cp_pkg::PIXEL_W-1:0]       req_pixel,
   input  logic                               req_frame_start,
   input  r4cp_pkg::cfg_type                  cfg,
   input  logic [$clog2(DEPTH+1)-1:0]         queue_count,
   output logic                               push,
   output r4cp_pkg::entry_type                push_entry
);
   import r4cp_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic              accept;
   logic [4:0]        r5;
   logic [5:0]        g6;
   logic [4:0]        b5;
   logic [CHAN_W-1:0] r_exp;
   logic [CHAN_W-1:0] g_exp;
   logic [CHAN_W-1:0] b_exp;
   logic [CHAN_W-1:0] hi;
   logic [CHAN_W-1:0] lo;
   logic [SUM_W-1:0]  sum;

   logic              valid_ff;
   logic              start_ff;
   logic [CHAN_W-1:0] r_ff;
   logic [CHAN_W-1:0] g_ff;
   logic [CHAN_W-1:0] b_ff;
   logic [CHAN_W-1:0] sat_ff;
   logic [SUM_W-1:0]  sum_ff;

   logic [SUM_W-1:0]  lum_thr;
   logic [CODE_W-1:0] bw_code;
   logic              is_yellow;
   logic              is_red;
   logic [CODE_W-1:0] code;

   // Credit check: everything in flight must fit in the queue
   assign req_stall = ({1'b0, queue_count} + (CNT_W + 1)'(valid_ff)) >= (CNT_W + 1)'(DEPTH);
   assign accept    = req_valid && !req_stall;

   // Channel expansion by bit replication
   assign r5    = req_pixel[15:11];
   assign g6    = req_pixel[10:5];
   assign b5    = req_pixel[4:0];
   assign r_exp = {r5, r5[4:2]};
   assign g_exp = {g6, g6[5:4]};
   assign b_exp = {b5, b5[4:2]};

   // Luminance sum and channel extremes
   always_comb begin
      sum = WEIGHT_R * SUM_W'(r_exp) + WEIGHT_G * SUM_W'(g_exp) + WEIGHT_B * SUM_W'(b_exp);
      hi  = (r_exp > g_exp) ? ((r_exp > b_exp) ? r_exp : b_exp)
                            : ((g_exp > b_exp) ? g_exp : b_exp);
      lo  = (r_exp < g_exp) ? ((r_exp < b_exp) ? r_exp : b_exp)
                            : ((g_exp < b_exp) ? g_exp : b_exp);
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) begin
         start_ff <= req_frame_start;
         r_ff     <= r_exp;
         g_ff     <= g_exp;
         b_ff     <= b_exp;
         sat_ff   <= hi - lo;
         sum_ff   <= sum;
      end
   end

   // Color decision against the configured windows
   always_comb begin
      lum_thr   = SUM_W'(cfg.lum_limit) * LUM_SCALE;
      bw_code   = (sum_ff < lum_thr) ? COLOR_BLACK : COLOR_WHITE;
      is_yellow = (r_ff > cfg.yellow_red_min) && (g_ff > cfg.yellow_green_min) &&
                  (b_ff < cfg.yellow_blue_max);
      is_red    = (r_ff > cfg.red_red_min) && (g_ff < cfg.red_green_max) &&
                  (b_ff < cfg.red_blue_max);
      if (sat_ff < cfg.sat_limit) begin
         code = bw_code;
      end else if (is_yellow) begin
         code = COLOR_YELLOW;
      end else if (is_red) begin
         code = COLOR_RED;
      end else begin
         code = bw_code;
      end
   end

   assign push                   = valid_ff;
   assign push_entry.frame_start = start_ff;
   assign push_entry.code        = code;

endmodule

// File: rtl/r4cp_queue.sv
// Small register queue of classified pixels between the front and back ends.
module r4cp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  r4cp_pkg::entry_type          push_entry,
   input  logic                         pop,
   output logic                         not_empty,
   output r4cp_pkg::entry_type          head_entry,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   import r4cp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_in;
   logic               do_pop;

   assign not_empty  = count_ff != '0;
   assign head_entry = entries_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_pop     = pop && not_empty;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/r4cp_pack.sv
// Back end: groups four color codes into a byte and holds it in the output register.
module r4cp_pack (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         not_empty,
   input  r4cp_pkg::entry_type          head_entry,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [r4cp_pkg::BYTE_W-1:0]  rsp_packed_byte
);
   import r4cp_pkg::*;

   logic [1:0]        phase_ff;
   logic [5:0]        pending_ff;
   logic              valid_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [1:0]        phase_in;
   logic [5:0]        pending_in;
   logic              valid_in;
   logic [1:0]        cur_phase;
   logic [5:0]        cur_pending;
   logic              emit;

   // Take a code whenever the output register is free or draining
   assign pop = not_empty && (!valid_ff || !rsp_stall);

   // Grouping: frame start restarts the group
   always_comb begin
      cur_phase   = head_entry.frame_start ? 2'd0 : phase_ff;
      cur_pending = head_entry.frame_start ? 6'd0 : pending_ff;
      emit        = pop && (cur_phase == 2'd3);
      phase_in    = phase_ff;
      pending_in  = pending_ff;
      if (pop) begin
         if (cur_phase == 2'd3) begin
            phase_in   = 2'd0;
            pending_in = 6'd0;
         end else begin
            phase_in   = cur_phase + 2'd1;
            pending_in = {cur_pending[3:0], head_entry.code};
         end
      end
      valid_in = emit || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 2'd0;
         pending_ff <= 6'd0;
         valid_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         valid_ff   <= valid_in;
      end
      if (emit) begin
         byte_ff <= {cur_pending, head_entry.code};
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_packed_byte = byte_ff;

endmodule

// File: rtl/rgb565_to_four_color_packer.sv
// A byte is valid once its fourth pixel has passed the stage register and the queue.
// Throughput: one pixel per cycle while req_stall is low; one byte per four pixels.
// Pixels stall once the classify stage plus the QUEUE_DEPTH-entry queue hold QUEUE_DEPTH.
// Reset (synchronous): clears the group, the queue and the output; registers take defaults.
// The configuration port is always ready; writes beyond the register list are dropped.
module rgb565_to_four_color_packer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [r4cp_pkg::PIXEL_W-1:0]       req_pixel,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [r4cp_pkg::BYTE_W-1:0]        rsp_packed_byte,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [r4cp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [r4cp_pkg::CHAN_W-1:0]        csr_wdata
);
   import r4cp_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic             push;
   entry_type        push_entry;
   logic             pop;
   logic             not_empty;
   entry_type        head_entry;
   logic [CNT_W-1:0] queue_count;

   assign csr_ready = 1'b1;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SAT_LIMIT:        cfg_in.sat_limit        = csr_wdata;
            REG_LUM_LIMIT:        cfg_in.lum_limit        = csr_wdata;
            REG_YELLOW_RED_MIN:   cfg_in.yellow_red_min   = csr_wdata;
            REG_YELLOW_GREEN_MIN: cfg_in.yellow_green_min = csr_wdata;
            REG_YELLOW_BLUE_MAX:  cfg_in.yellow_blue_max  = csr_wdata;
            REG_RED_RED_MIN:      cfg_in.red_red_min      = csr_wdata;
            REG_RED_GREEN_MAX:    cfg_in.red_green_max    = csr_wdata;
            REG_RED_BLUE_MAX:     cfg_in.red_blue_max     = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sat_limit        <= RST_SAT_LIMIT;
         cfg_ff.lum_limit        <= RST_LUM_LIMIT;
         cfg_ff.yellow_red_min   <= RST_YELLOW_RED_MIN;
         cfg_ff.yellow_green_min <= RST_YELLOW_GREEN_MIN;
         cfg_ff.yellow_blue_max  <= RST_YELLOW_BLUE_MAX;
         cfg_ff.red_red_min      <= RST_RED_RED_MIN;
         cfg_ff.red_green_max    <= RST_RED_GREEN_MAX;
         cfg_ff.red_blue_max     <= RST_RED_BLUE_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accept and classify
   r4cp_classify #(
      .DEPTH(QUEUE_DEPTH)
   ) u_classify (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .cfg             (cfg_ff),
      .queue_count     (queue_count),
      .push            (push),
      .push_entry      (push_entry)
   );

   // Decoupling queue
   r4cp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .not_empty  (not_empty),
      .head_entry (head_entry),
      .count      (queue_count)
   );

   // Back end: group and emit
   r4cp_pack u_pack (
      .clock           (clock),
      .reset           (reset),
      .not_empty       (not_empty),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_byte (rsp_packed_byte)
   );

endmodule

// File: rtl/r4cp_checker.sv
// Port-level checker for the four-color packer, bound to the top level.
module r4cp_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [r4cp_pkg::BYTE_W-1:0]        rsp_packed_byte,
   input  logic                               csr_ready
);
   import r4cp_pkg::*;

   // A stalled result transaction holds its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_packed_byte))
      else $error("stalled result changed or dropped");

   // Reset empties the output and the front end
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear output or front end");

   // A pixel stream never stalls for good while the output sits idle
   assert property (@(posedge clock) disable iff (reset)
      req_stall && !rsp_valid && $past(!rsp_valid) |=> !req_stall || $past(req_valid))
      else $error("input stalled with an idle output");

   // Configuration writes are never held off
   assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port not ready");

endmodule

bind rgb565_to_four_color_packer r4cp_checker u_r4cp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_packed_byte (rsp_packed_byte),
   .csr_ready       (csr_ready)
);
